// ===== rtl/core/mci_pkg.sv =====
package mci_pkg;

  localparam int DEF_MAX_TILE_WIDTH  = 64;
  localparam int DEF_MAX_TILE_HEIGHT = 64;
  localparam int DEF_FRAC_BITS       = 28;

  localparam int PIX_W       = 6;
  localparam int COORD_DEPTH = 2 ** PIX_W;
  localparam int IDX_W       = 13;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 32;
  localparam int BADDR_W     = 11;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  localparam logic [31:0] RST_REAL_MIN   = 32'hE000_0000;
  localparam logic [31:0] RST_REAL_MAX   = 32'h1000_0000;
  localparam logic [31:0] RST_IMAG_MIN   = 32'hE800_0000;
  localparam logic [31:0] RST_IMAG_MAX   = 32'h1800_0000;
  localparam logic [6:0]  RST_TILE_W     = 7'd64;
  localparam logic [6:0]  RST_TILE_H     = 7'd64;
  localparam logic [7:0]  RST_ITER_LIMIT = 8'd32;
  localparam logic [5:0]  RST_ROW_BYTES  = 6'd8;

  typedef enum logic [2:0] {
    REG_REAL_MIN   = 3'd0,
    REG_REAL_MAX   = 3'd1,
    REG_IMAG_MIN   = 3'd2,
    REG_IMAG_MAX   = 3'd3,
    REG_TILE_W     = 3'd4,
    REG_TILE_H     = 3'd5,
    REG_ITER_LIMIT = 3'd6,
    REG_ROW_BYTES  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] real_min;
    logic signed [31:0] real_max;
    logic signed [31:0] imag_min;
    logic signed [31:0] imag_max;
    logic [6:0]         tile_width;
    logic [6:0]         tile_height;
  } region_t;

  typedef struct packed {
    logic signed [31:0] z_re;
    logic signed [31:0] z_im;
    logic [7:0]         count;
    logic               solved;
  } cell_t;

  typedef struct packed {
    logic [7:0]         count;
    logic [2:0]         bit_pos;
    logic [BADDR_W-1:0] byte_addr;
    logic               pix_val;
    logic               pix_wr;
    logic               did;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] == {35{v[65]}}) r = v[31:0];
    else if (v[65]) r = 32'sh8000_0000;
    else r = 32'sh7FFF_FFFF;
    return r;
  endfunction

endpackage

// ===== rtl/core/mci_cell_ram.sv =====
module mci_cell_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic           clk,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output mci_pkg::cell_t rd_data,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  mci_pkg::cell_t wr_data
);
  import mci_pkg::*;

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/mci_coord_gen.sv =====
module mci_coord_gen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  mci_pkg::region_t          region,
  input  logic                      rd_en,
  input  logic [mci_pkg::PIX_W-1:0] rd_x,
  input  logic [mci_pkg::PIX_W-1:0] rd_y,
  output logic signed [31:0]        c_re,
  output logic signed [31:0]        c_im,
  output logic                      busy
);
  import mci_pkg::*;

  typedef enum logic [3:0] {
    CG_IDLE = 4'b0001,
    CG_LOAD = 4'b0010,
    CG_DIV  = 4'b0100,
    CG_FILL = 4'b1000
  } cg_state_t;

  cg_state_t          state_r, state_nxt;
  logic               axis_r, axis_nxt;
  logic signed [31:0] lo_r;
  logic               neg_r;
  logic [31:0]        dvd_r;
  logic [6:0]         size_r;
  logic [7:0]         rem_r;
  logic [DIV_CW-1:0]  step_r;
  logic [PIX_W-1:0]   p_r;
  logic [37:0]        accq_r;
  logic [6:0]         accr_r;

  logic signed [31:0] tab_re [COORD_DEPTH];
  logic signed [31:0] tab_im [COORD_DEPTH];
  logic signed [31:0] c_re_r, c_im_r;

  logic signed [31:0] lo_sel, hi_sel;
  logic signed [32:0] delta;
  logic [32:0]        delta_mag;
  logic [7:0]         rem_sh;
  logic               rem_ge;
  logic [7:0]         acc_tmp;
  logic               acc_carry;
  logic signed [65:0] lo_ext, acc_ext;
  logic signed [31:0] entry;

  assign lo_sel    = axis_r ? region.imag_min : region.real_min;
  assign hi_sel    = axis_r ? region.imag_max : region.real_max;
  assign delta     = 33'(hi_sel) - 33'(lo_sel);
  assign delta_mag = delta[32] ? 33'(-delta) : 33'(delta);

  assign rem_sh = {rem_r[6:0], dvd_r[31]};
  assign rem_ge = rem_sh >= {1'b0, size_r};

  assign acc_tmp   = {1'b0, accr_r} + {1'b0, rem_r[6:0]};
  assign acc_carry = acc_tmp >= {1'b0, size_r};

  assign lo_ext  = 66'(lo_r);
  assign acc_ext = $signed({28'b0, accq_r});
  assign entry   = sat32(neg_r ? lo_ext - acc_ext : lo_ext + acc_ext);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      CG_IDLE: state_nxt = CG_IDLE;
      CG_LOAD: state_nxt = CG_DIV;
      CG_DIV:  if (step_r == DIV_CW'(DIV_STEPS - 1)) state_nxt = CG_FILL;
      CG_FILL: begin
        if (p_r == PIX_W'(COORD_DEPTH - 1)) begin
          if (axis_r) begin
            state_nxt = CG_IDLE;
          end else begin
            state_nxt = CG_LOAD;
            axis_nxt  = 1'b1;
          end
        end
      end
      default: state_nxt = CG_IDLE;
    endcase
    if (start) begin
      state_nxt = CG_LOAD;
      axis_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CG_LOAD;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      CG_LOAD: begin
        lo_r   <= lo_sel;
        neg_r  <= delta[32];
        dvd_r  <= delta_mag[31:0];
        size_r <= axis_r ? region.tile_height : region.tile_width;
        rem_r  <= '0;
        step_r <= '0;
      end
      CG_DIV: begin
        rem_r  <= rem_ge ? rem_sh - {1'b0, size_r} : rem_sh;
        dvd_r  <= {dvd_r[30:0], rem_ge};
        step_r <= step_r + DIV_CW'(1);
        p_r    <= '0;
        accq_r <= '0;
        accr_r <= '0;
      end
      CG_FILL: begin
        accq_r <= accq_r + 38'(dvd_r) + 38'(acc_carry);
        accr_r <= acc_carry ? 7'(acc_tmp - {1'b0, size_r}) : acc_tmp[6:0];
        p_r    <= p_r + PIX_W'(1);
      end
      default: ;
    endcase
  end

  // coordinate tables, one entry per column and per row
  always_ff @(posedge clk) begin
    if (state_r == CG_FILL) begin
      if (axis_r) tab_im[p_r] <= entry;
      else tab_re[p_r] <= entry;
    end
    if (rd_en) begin
      c_re_r <= tab_re[rd_x];
      c_im_r <= tab_im[rd_y];
    end
  end

  assign c_re = c_re_r;
  assign c_im = c_im_r;
  assign busy = state_r != CG_IDLE;

endmodule

// ===== rtl/core/mci_out_fifo.sv =====
module mci_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mci_pkg::res_t din,
  input  logic          pop,
  output mci_pkg::res_t dout,
  output logic          valid
);
  import mci_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign cnt_nxt = cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + FIFO_AW'(1);
      if (pop) rptr_r <= rptr_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= din;
  end

  assign dout  = mem[rptr_r];
  assign valid = cnt_r != '0;

endmodule

// ===== rtl/core/mandelbrot_cell_iterator.sv =====
// channel | dir | beat contents (lsb first)
// in_     | in  | tdata: pixel_x[5:0], pixel_y[11:6]; tuser: op
// out_    | out | tdata: did_iterate, pixel_write, pixel_value, byte_address[13:3],
//         |     |        bit_position[16:14], iteration_count[24:17]
// cfg_    | in  | index 0..7, 32 bit data
// one cell per cycle while in_tready is high; a beat's result passes stages 1 to 4 and a buffer to out_
// a cell still in the 4 stage read-modify-write loop holds off a beat on the same cell
// reset runs a clearing pass over all MAX_TILE_WIDTH*MAX_TILE_HEIGHT cells of the cell store
// reset and every cfg write rebuild the coordinate tables
// up to 8 results buffer while out_tready is low, input stops after that
module mandelbrot_cell_iterator #(
  parameter int MAX_TILE_WIDTH  = mci_pkg::DEF_MAX_TILE_WIDTH,
  parameter int MAX_TILE_HEIGHT = mci_pkg::DEF_MAX_TILE_HEIGHT,
  parameter int FRAC_BITS       = mci_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mci_pkg::IN_DATA_W-1:0]   in_tdata,  // pixel_x, pixel_y
  input  logic [0:0]                      in_tuser,  // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mci_pkg::OUT_DATA_W-1:0]  out_tdata, // did, wr, val, addr, bit, count
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [31:0]                     cfg_data
);
  import mci_pkg::*;

  localparam int CELL_DEPTH = MAX_TILE_WIDTH * MAX_TILE_HEIGHT;
  localparam int AW         = $clog2(CELL_DEPTH);
  localparam logic signed [64:0] ESC_LIM = 65'sd1 <<< (FRAC_BITS + 2);

  // configuration
  region_t    region_r;
  logic [7:0] limit_r;
  logic [5:0] rb_r;
  logic       cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r.real_min    <= RST_REAL_MIN;
      region_r.real_max    <= RST_REAL_MAX;
      region_r.imag_min    <= RST_IMAG_MIN;
      region_r.imag_max    <= RST_IMAG_MAX;
      region_r.tile_width  <= RST_TILE_W;
      region_r.tile_height <= RST_TILE_H;
      limit_r              <= RST_ITER_LIMIT;
      rb_r                 <= RST_ROW_BYTES;
    end else if (cfg_acc) begin
      case (cfg_reg_t'(cfg_index))
        REG_REAL_MIN:   region_r.real_min    <= cfg_data;
        REG_REAL_MAX:   region_r.real_max    <= cfg_data;
        REG_IMAG_MIN:   region_r.imag_min    <= cfg_data;
        REG_IMAG_MAX:   region_r.imag_max    <= cfg_data;
        REG_TILE_W:     region_r.tile_width  <= cfg_data[6:0];
        REG_TILE_H:     region_r.tile_height <= cfg_data[6:0];
        REG_ITER_LIMIT: limit_r              <= cfg_data[7:0];
        REG_ROW_BYTES:  rb_r                 <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(CELL_DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  // stage 0: decode
  logic [PIX_W-1:0]   px0, py0;
  logic               op0;
  logic [IDX_W-1:0]   idx0;
  logic [AW-1:0]      addr0;
  logic               inside0;
  logic [BADDR_W-1:0] baddr0;
  logic               hazard, accept, pop, cg_busy;
  logic [FIFO_CW-1:0] inflight_r, inflight_nxt;

  assign px0     = in_tdata[5:0];
  assign py0     = in_tdata[11:6];
  assign op0     = in_tuser[0];
  assign idx0    = IDX_W'(py0) * IDX_W'(region_r.tile_width) + IDX_W'(px0);
  assign addr0   = AW'(idx0);
  assign inside0 = (7'(px0) < region_r.tile_width) && (7'(py0) < region_r.tile_height)
                   && (32'(idx0) < 32'(CELL_DEPTH));
  assign baddr0  = BADDR_W'(py0) * BADDR_W'(rb_r) + BADDR_W'(px0[5:3]);

  // stage registers
  logic               v1_r, v2_r, v3_r, v4_r;
  logic               op1_r, op2_r, op3_r, op4_r;
  logic               in1_r, in2_r, in3_r, in4_r;
  logic [AW-1:0]      idx1_r, idx2_r, idx3_r, idx4_r;
  logic [BADDR_W-1:0] ba1_r, ba2_r, ba3_r, ba4_r;
  logic [2:0]         bp1_r, bp2_r, bp3_r, bp4_r;
  logic               sol2_r, sol3_r, sol4_r;
  logic [7:0]         cnto2_r, cnto3_r, cnto4_r;
  logic [7:0]         cntn2_r, cntn3_r, cntn4_r;
  logic signed [63:0] xx2_r, yy2_r, xy2_r, nxx4_r, nyy4_r;
  logic signed [31:0] cre2_r, cim2_r, nx3_r, ny3_r, nx4_r, ny4_r;

  assign hazard = inside0 && (
                  (v1_r && in1_r && idx1_r == addr0) || (v2_r && in2_r && idx2_r == addr0) ||
                  (v3_r && in3_r && idx3_r == addr0) || (v4_r && in4_r && idx4_r == addr0));

  assign in_tready = !clr_busy_r && !cg_busy && !hazard && (inflight_r < FIFO_CW'(FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // memories
  cell_t              rd_cell, wb_cell, ram_wdata;
  logic               wb_en, ram_we;
  logic [AW-1:0]      ram_waddr;
  logic signed [31:0] c_re, c_im;

  mci_cell_ram #(.DEPTH(CELL_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (addr0),
    .rd_data (rd_cell),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  mci_coord_gen u_coord (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_acc),
    .region (region_r),
    .rd_en  (accept),
    .rd_x   (px0),
    .rd_y   (py0),
    .c_re   (c_re),
    .c_im   (c_im),
    .busy   (cg_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1 -> 2: squares of the stored z
  logic signed [63:0] xx_nxt, yy_nxt, xy_nxt;
  assign xx_nxt = rd_cell.z_re * rd_cell.z_re;
  assign yy_nxt = rd_cell.z_im * rd_cell.z_im;
  assign xy_nxt = rd_cell.z_re * rd_cell.z_im;

  // stage 2 -> 3: z^2 + c
  logic signed [31:0] nx_nxt, ny_nxt;
  assign nx_nxt = sat32(66'(xx2_r >>> FRAC_BITS) - 66'(yy2_r >>> FRAC_BITS) + 66'(cre2_r));
  assign ny_nxt = sat32(66'(xy2_r >>> (FRAC_BITS - 1)) + 66'(cim2_r));

  always_ff @(posedge clk) begin
    op1_r   <= op0;
    in1_r   <= inside0;
    idx1_r  <= addr0;
    ba1_r   <= baddr0;
    bp1_r   <= ~px0[2:0];

    op2_r   <= op1_r;
    in2_r   <= in1_r;
    idx2_r  <= idx1_r;
    ba2_r   <= ba1_r;
    bp2_r   <= bp1_r;
    sol2_r  <= rd_cell.solved;
    cnto2_r <= rd_cell.count;
    cntn2_r <= (rd_cell.count == 8'hFF) ? rd_cell.count : rd_cell.count + 8'd1;
    xx2_r   <= xx_nxt;
    yy2_r   <= yy_nxt;
    xy2_r   <= xy_nxt;
    cre2_r  <= c_re;
    cim2_r  <= c_im;

    op3_r   <= op2_r;
    in3_r   <= in2_r;
    idx3_r  <= idx2_r;
    ba3_r   <= ba2_r;
    bp3_r   <= bp2_r;
    sol3_r  <= sol2_r;
    cnto3_r <= cnto2_r;
    cntn3_r <= cntn2_r;
    nx3_r   <= nx_nxt;
    ny3_r   <= ny_nxt;

    op4_r   <= op3_r;
    in4_r   <= in3_r;
    idx4_r  <= idx3_r;
    ba4_r   <= ba3_r;
    bp4_r   <= bp3_r;
    sol4_r  <= sol3_r;
    cnto4_r <= cnto3_r;
    cntn4_r <= cntn3_r;
    nx4_r   <= nx3_r;
    ny4_r   <= ny3_r;
    nxx4_r  <= nx3_r * nx3_r;
    nyy4_r  <= ny3_r * ny3_r;
  end

  // stage 4: escape test, write back, result
  logic signed [64:0] mag;
  logic               esc, lim, iter4;
  res_t               res, out_res;

  assign mag   = 65'(nxx4_r >>> FRAC_BITS) + 65'(nyy4_r >>> FRAC_BITS);
  assign esc   = mag >= ESC_LIM;
  assign lim   = cntn4_r > limit_r;
  assign iter4 = in4_r && !op4_r && !sol4_r;

  assign wb_en   = v4_r && in4_r && (op4_r || !sol4_r);
  assign wb_cell = op4_r ? cell_t'('0)
                         : cell_t'{z_re: nx4_r, z_im: ny4_r, count: cntn4_r, solved: esc || lim};

  assign ram_we    = clr_busy_r || wb_en;
  assign ram_waddr = clr_busy_r ? clr_addr_r : idx4_r;
  assign ram_wdata = clr_busy_r ? '0 : wb_cell;

  assign res.did       = iter4;
  assign res.pix_wr    = iter4 && (esc || lim);
  assign res.pix_val   = iter4 && lim;
  assign res.byte_addr = ba4_r;
  assign res.bit_pos   = bp4_r;
  assign res.count     = (!in4_r || op4_r) ? 8'd0 : (sol4_r ? cnto4_r : cntn4_r);

  mci_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (v4_r),
    .din   (res),
    .pop   (pop),
    .dout  (out_res),
    .valid (out_tvalid)
  );

  assign pop       = out_tvalid && out_tready;
  assign out_tdata = {7'b0, out_res.count, out_res.bit_pos, out_res.byte_addr,
                      out_res.pix_val, out_res.pix_wr, out_res.did};

  assign inflight_nxt = inflight_r + FIFO_CW'(accept) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_nxt;
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("in-flight count above buffer depth");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !v1_r && !v4_r)
    else $error("pipeline active during clearing pass");

  a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && in4_r && v1_r && in1_r |-> idx1_r != idx4_r)
    else $error("same cell read while write back pending");

  a_did_count: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && res.did |-> res.count != 8'd0)
    else $error("iteration with zero count");

  a_write_did: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && res.pix_wr |-> res.did)
    else $error("pixel write without iteration");

endmodule
